>>> sv/sdsb_pkg.sv
// ----------------------------------------------------------------------------
// sdsb_pkg
// Shared constants, request codes and controller/datapath interface types
// for the sorted sequence buffer.
// ----------------------------------------------------------------------------
package sdsb_pkg;

    localparam int DEPTH_DEF        = 32;
    localparam int PAYLOAD_BITS_DEF = 64;

    localparam int ID_W  = 32;
    localparam int REQ_W = 2;
    localparam int CAP_W = 6;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PEEK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

    typedef struct packed {
        logic insert;
        logic clear;
        logic trim;
        logic load_entry;
        logic load_empty;
        logic force_last;
        logic rd_inc;
        logic rd_clr;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic over_cap;
        logic rd_last;
        logic res_free;
    } status_t;

endpackage

>>> sv/sdsb_ctrl.sv
// ----------------------------------------------------------------------------
// sdsb_ctrl
// Request sequencer: decodes accepted requests, runs the trim loop after an
// add and steps the ordered read-out one entry per cycle while the result register is free.
// ----------------------------------------------------------------------------
module sdsb_ctrl
    import sdsb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [REQ_W-1:0] req_type,
    output logic             req_ready,
    input  status_t          sts,
    output cmd_t             cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_STREAM = 3'b010,
        ST_TRIM   = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign req_ready = (state_reg == ST_IDLE) && sts.res_free;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_ADD:
                        begin
                            cmd.insert = 1'b1;
                            state_next = ST_TRIM;
                        end
                        REQ_PEEK:
                        begin
                            if (sts.empty)
                            begin
                                cmd.load_empty = 1'b1;
                            end
                            else
                            begin
                                cmd.load_entry = 1'b1;
                                cmd.force_last = 1'b1;
                            end
                        end
                        REQ_READ:
                        begin
                            if (sts.empty)
                            begin
                                cmd.load_empty = 1'b1;
                            end
                            else
                            begin
                                cmd.load_entry = 1'b1;
                                if (!sts.rd_last)
                                begin
                                    cmd.rd_inc = 1'b1;
                                    state_next = ST_STREAM;
                                end
                            end
                        end
                        REQ_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        default:
                        begin
                            cmd.clear = 1'b0;
                        end
                    endcase
                end
            end
            ST_STREAM:
            begin
                if (sts.res_free)
                begin
                    cmd.load_entry = 1'b1;
                    if (sts.rd_last)
                    begin
                        cmd.rd_clr = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.rd_inc = 1'b1;
                    end
                end
            end
            ST_TRIM:
            begin
                // drop the smallest entry each cycle until within capacity
                if (sts.over_cap)
                begin
                    cmd.trim = 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/sdsb_dp.sv
// ----------------------------------------------------------------------------
// sdsb_dp
// Row of sorted cells with parallel compare-and-shift insert, shift-down
// trim, capacity register, read pointer and result register.
// ----------------------------------------------------------------------------
module sdsb_dp
    import sdsb_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output status_t                 sts,
    input  logic                    cfg_we,
    input  logic [CAP_W-1:0]        cfg_data,
    input  logic [ID_W-1:0]         item_id,
    input  logic [PAYLOAD_BITS-1:0] item_payload,
    input  logic                    res_ready,
    output logic                    res_valid,
    output logic                    out_valid,
    output logic [ID_W-1:0]         out_id,
    output logic [PAYLOAD_BITS-1:0] out_payload,
    output logic                    out_last
);

    // one spare cell holds the new entry before the trim drops one
    localparam int NCELL = DEPTH + 1;
    localparam int CNT_W = $clog2(DEPTH + 2);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SEL_W = $clog2(NCELL);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [ID_W-1:0]         id_reg [NCELL];
    logic [PAYLOAD_BITS-1:0] pl_reg [NCELL];

    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [SEL_W-1:0] rd_sel;
    logic [CAP_W-1:0] cap_reg;
    logic [CMP_W-1:0] eff_cap;

    logic                    res_valid_reg;
    logic                    ov_reg;
    logic                    olast_reg;
    logic [ID_W-1:0]         oid_reg;
    logic [PAYLOAD_BITS-1:0] opl_reg;

    logic [NCELL-1:0] lt;
    logic [NCELL-1:0] eq;
    logic [NCELL-1:0] lt_prev;
    logic [NCELL-1:0] at_pos;
    logic [NCELL-1:0] shift_en;
    logic             dup;
    logic             do_insert;

    always_comb
    begin
        for (int i = 0; i < NCELL; i++)
        begin
            lt[i] = (CNT_W'(i) < count_reg) && (id_reg[i] < item_id);
            eq[i] = (CNT_W'(i) < count_reg) && (id_reg[i] == item_id);
        end
    end

    // cell i sees whether cell i-1 stays put; cell 0 has nothing below it
    assign lt_prev   = {lt[NCELL-2:0], 1'b1};
    assign at_pos    = ~lt & lt_prev;
    assign shift_en  = ~lt & ~lt_prev;
    assign dup       = |eq;
    assign do_insert = cmd.insert && !dup;
    assign rd_sel    = SEL_W'(rd_idx_reg);

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(DEPTH))
        begin
            eff_cap = CMP_W'(DEPTH);
        end
        else
        begin
            eff_cap = CMP_W'(cap_reg);
        end
    end

    assign sts.empty    = (count_reg == '0);
    assign sts.over_cap = (CMP_W'(count_reg) > eff_cap);
    assign sts.rd_last  = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg);
    assign sts.res_free = !res_valid_reg || res_ready;

    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            for (int i = 0; i < NCELL; i++)
            begin
                if (at_pos[i])
                begin
                    id_reg[i] <= item_id;
                    pl_reg[i] <= item_payload;
                end
            end
            for (int i = 1; i < NCELL; i++)
            begin
                if (shift_en[i])
                begin
                    id_reg[i] <= id_reg[i-1];
                    pl_reg[i] <= pl_reg[i-1];
                end
            end
        end
        else if (cmd.trim)
        begin
            for (int i = 0; i < NCELL - 1; i++)
            begin
                id_reg[i] <= id_reg[i+1];
                pl_reg[i] <= pl_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            cap_reg       <= CAP_RESET;
            res_valid_reg <= 1'b0;
            ov_reg        <= 1'b0;
            olast_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (do_insert)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.trim)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end

            if (cmd.rd_clr)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.rd_inc)
            begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end

            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end

            if (cmd.load_entry)
            begin
                res_valid_reg <= 1'b1;
                ov_reg        <= 1'b1;
                olast_reg     <= cmd.force_last || sts.rd_last;
            end
            else if (cmd.load_empty)
            begin
                res_valid_reg <= 1'b1;
                ov_reg        <= 1'b0;
                olast_reg     <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_entry)
        begin
            oid_reg <= id_reg[rd_sel];
            opl_reg <= pl_reg[rd_sel];
        end
        else if (cmd.load_empty)
        begin
            oid_reg <= '0;
            opl_reg <= '0;
        end
    end

    assign res_valid   = res_valid_reg;
    assign out_valid   = ov_reg;
    assign out_id      = oid_reg;
    assign out_payload = opl_reg;
    assign out_last    = olast_reg;

endmodule

>>> sv/sorted_dedup_sequence_buffer.sv
// ----------------------------------------------------------------------------
// sorted_dedup_sequence_buffer
// Bounded buffer of entries kept in ascending sequence-id order, with
// duplicate rejection, capacity trim, peek, ordered read-out and clear.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  request   req_valid / req_ready  req_type, item_id, item_payload
//  result    res_valid / res_ready  out_valid, out_id, out_payload, out_last
//  config    cfg_we                 cfg_data (capacity)
//
//  add: inserts through the cell row, then checks capacity in the trim state
//  and drops entries while over capacity (the trim shifts one slot a cycle)
//  peek and clear complete from the idle state; read all: one result per stored entry,
//  paced by the single result register
//  a request is taken only when the result register is free or being drained
//  reset empties the buffer at once and sets capacity to 32; no sweep needed
// ----------------------------------------------------------------------------
module sorted_dedup_sequence_buffer
    import sdsb_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic [REQ_W-1:0]        req_type,
    input  logic [ID_W-1:0]         item_id,
    input  logic [PAYLOAD_BITS-1:0] item_payload,
    output logic                    res_valid,
    input  logic                    res_ready,
    output logic                    out_valid,
    output logic [ID_W-1:0]         out_id,
    output logic [PAYLOAD_BITS-1:0] out_payload,
    output logic                    out_last,
    input  logic                    cfg_we,
    input  logic [CAP_W-1:0]        cfg_data
);

    cmd_t    cmd;
    status_t sts;

    sdsb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req_type),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sdsb_dp #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .item_id      (item_id),
        .item_payload (item_payload),
        .res_ready    (res_ready),
        .res_valid    (res_valid),
        .out_valid    (out_valid),
        .out_id       (out_id),
        .out_payload  (out_payload),
        .out_last     (out_last)
    );

    // an empty result is always the final one and carries zeros
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !out_valid) |-> (out_last && out_id == '0))
        else $error("empty result without last or with nonzero id");

    // a pending transaction is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_entry || cmd.load_empty) |-> sts.res_free)
        else $error("result register loaded while occupied");

    // after an insert the capacity check runs before the next request
    a_trim_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |=> !req_ready)
        else $error("request taken before capacity check");

endmodule
